[hw/rtl/cewh_pkg.sv]
// Shared types and constants of the cosine edge-weight histogram unit.
package cewh_pkg;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_SQRT,
    OP_DIV
  } arith_op_e;

  typedef enum logic [1:0] {
    AS_IDLE,
    AS_SQRT,
    AS_DIV
  } arith_state_e;

  typedef struct packed {
    logic        start;
    arith_op_e   op;
    logic [63:0] opa;
    logic [63:0] opb;
  } arith_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] result;
  } arith_rsp_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_INIT,
    S_CLR,
    S_N_PIX,
    S_N_RD,
    S_N_MUL,
    S_N_MACW,
    S_N_SQ,
    S_N_SQW,
    S_P_PIX,
    S_P_CHK,
    S_P_RDP,
    S_P_RDQ,
    S_P_MUL,
    S_P_MACW,
    S_P_NRP,
    S_P_NRQ,
    S_P_DQ,
    S_P_DQW,
    S_P_COS,
    S_P_COSW,
    S_P_RSQ,
    S_P_RSQW,
    S_P_RAT,
    S_P_RATW,
    S_P_BIN,
    S_P_BINW,
    S_P_HRD,
    S_P_HWR,
    S_DONE
  } seq_state_e;

  typedef enum logic [1:0] {
    OUT_NONE,
    OUT_BIN,
    OUT_EDGE,
    OUT_RUN
  } out_kind_e;

  localparam logic [1:0] MODE_LOAD      = 2'd0;
  localparam logic [1:0] MODE_RUN       = 2'd1;
  localparam logic [1:0] MODE_READ_BIN  = 2'd2;
  localparam logic [1:0] MODE_READ_EDGE = 2'd3;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_BANDS  = 2'd2;
  localparam logic [1:0] CFG_RADIUS = 2'd3;

  localparam logic [8:0] WIDTH_RESET  = 9'd256;
  localparam logic [8:0] HEIGHT_RESET = 9'd256;
  localparam logic [5:0] BANDS_RESET  = 6'd3;
  localparam logic [7:0] RADIUS_RESET = 8'd16;

  localparam logic [63:0] Q31_ONE      = 64'h0000_0000_8000_0000;
  localparam logic [63:0] SQRT_TOP_BIT = 64'h4000_0000_0000_0000;
  localparam logic [63:0] ROUND_HALF   = 64'h0000_2000_0000_0000;
  localparam logic [31:0] COUNT_MAX    = 32'hFFFF_FFFF;

  localparam int SQRT_STEPS   = 32;
  localparam int DIV_STEPS    = 31;
  localparam int NUM_SHIFT    = 24;
  localparam int DIST_SHIFT   = 40;
  localparam int RADIUS_SHIFT = 16;

endpackage

[hw/rtl/cewh_ram.sv]
// Generic single-port RAM with registered read.
module cewh_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic [AW-1:0]    addr_i,
  input  logic             we_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

[hw/rtl/cewh_arith.sv]
// Shared arithmetic unit: registered multiply, bit-serial square root and fraction divide.
module cewh_arith (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cewh_pkg::arith_req_t req_i,
  output cewh_pkg::arith_rsp_t rsp_o
);
  import cewh_pkg::*;

  arith_state_e state_q, state_d;
  logic [63:0]  rem_q, rem_d;
  logic [63:0]  res_q, res_d;
  logic [63:0]  aux_q, aux_d;
  logic [4:0]   cnt_q, cnt_d;
  logic         done_q, done_d;
  logic [63:0]  sq_trial;
  logic         sq_fit;
  logic [64:0]  div_shift;
  logic         div_fit;
  logic         step_last;
  logic [63:0]  prod;

  assign sq_trial  = res_q + aux_q;
  assign sq_fit    = rem_q >= sq_trial;
  assign div_shift = {rem_q, 1'b0};
  assign div_fit   = div_shift >= {1'b0, aux_q};
  assign step_last = (state_q == AS_SQRT) ? (cnt_q == 5'(SQRT_STEPS - 1))
                                          : (cnt_q == 5'(DIV_STEPS - 1));
  assign prod      = req_i.opa[31:0] * req_i.opb[31:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      AS_IDLE: begin
        if (req_i.start) begin
          unique case (req_i.op)
            OP_SQRT: state_d = AS_SQRT;
            OP_DIV: begin
              if (req_i.opa < req_i.opb) state_d = AS_DIV;
            end
            default: state_d = AS_IDLE;
          endcase
        end
      end
      AS_SQRT, AS_DIV: begin
        if (step_last) state_d = AS_IDLE;
      end
      default: state_d = AS_IDLE;
    endcase
  end

  always_comb begin
    rem_d  = rem_q;
    res_d  = res_q;
    aux_d  = aux_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    unique case (state_q)
      AS_IDLE: begin
        if (req_i.start) begin
          cnt_d = '0;
          unique case (req_i.op)
            OP_MUL: begin
              res_d  = prod;
              done_d = 1'b1;
            end
            OP_SQRT: begin
              rem_d = req_i.opa;
              res_d = '0;
              aux_d = SQRT_TOP_BIT;
            end
            OP_DIV: begin
              // quotient of one or more saturates at once
              if (req_i.opa >= req_i.opb) begin
                res_d  = Q31_ONE;
                done_d = 1'b1;
              end else begin
                rem_d = req_i.opa;
                res_d = '0;
                aux_d = req_i.opb;
              end
            end
            default: done_d = 1'b0;
          endcase
        end
      end
      AS_SQRT: begin
        if (sq_fit) begin
          rem_d = rem_q - sq_trial;
          res_d = (res_q >> 1) + aux_q;
        end else begin
          res_d = res_q >> 1;
        end
        aux_d  = aux_q >> 2;
        cnt_d  = cnt_q + 5'd1;
        done_d = step_last;
      end
      AS_DIV: begin
        if (div_fit) begin
          rem_d = 64'(div_shift - {1'b0, aux_q});
          res_d = {res_q[62:0], 1'b1};
        end else begin
          rem_d = div_shift[63:0];
          res_d = {res_q[62:0], 1'b0};
        end
        cnt_d  = cnt_q + 5'd1;
        done_d = step_last;
      end
      default: done_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= AS_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    res_q <= res_d;
    aux_q <= aux_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = res_q;

endmodule

[hw/rtl/cosine_edge_weight_histogram_unit.sv]
// Top level: command decode, run sequencer, image, norm and histogram memories.
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+----------------------------------------------
//  command   | start_i, busy_o           | mode_i column_i row_i band_i sample_i bin_index_i
//  result    | result_valid_o (strobe)   | read_value_o run_done_o
//  config    | cfg_valid_i, cfg_ready_o  | cfg_index_i cfg_data_i
//
// Loads write the image on accept; bin and edge reads answer in the cycle after the command.
// A run clears the histogram, then computes a norm for each pixel, then walks the offsets
// of each pixel, skipping those out of range, and bins each edge with the shared
// arithmetic unit (32-step square root, 31-step divide) and the single-port image RAM.
// busy_o stays high for the whole run; config writes only while idle.
// Reset clears control state and sets config to its reset values, then busy_o holds while the
// histogram is cleared; image contents are undefined until loaded.
// The receiver cannot stall: each result strobes for exactly one cycle.
module cosine_edge_weight_histogram_unit #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_BANDS  = 32,
  parameter int BIN_COUNT  = 65537
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  column_i,
  input  logic [7:0]  row_i,
  input  logic [4:0]  band_i,
  input  logic [15:0] sample_i,
  input  logic [16:0] bin_index_i,
  output logic        result_valid_o,
  output logic [31:0] read_value_o,
  output logic        run_done_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [8:0]  cfg_data_i
);
  import cewh_pkg::*;

  localparam int XCW       = $clog2(MAX_WIDTH + 1);
  localparam int YCW       = $clog2(MAX_HEIGHT + 1);
  localparam int KCW       = $clog2(MAX_BANDS + 1);
  localparam int PIX_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int IMG_DEPTH = PIX_DEPTH * MAX_BANDS;
  localparam int PW        = (PIX_DEPTH > 1) ? $clog2(PIX_DEPTH) : 1;
  localparam int IW        = (IMG_DEPTH > 1) ? $clog2(IMG_DEPTH) : 1;
  localparam int BW        = $clog2(BIN_COUNT);
  localparam int CW        = (XCW > YCW) ? XCW : YCW;
  localparam int NW        = ((CW > 5) ? CW : 5) + 2;

  seq_state_e state_q, state_d;

  logic [8:0] width_q, height_q;
  logic [5:0] bands_q;
  logic [7:0] radius_q;

  logic [XCW-1:0] x_q, x_d, w_eff;
  logic [YCW-1:0] y_q, y_d, h_eff;
  logic [KCW-1:0] k_q, k_d, nb_eff;
  logic signed [4:0] dx_q, dx_d, dy_q, dy_d, span_s;
  logic [39:0]    acc_q, acc_d;
  logic [16:0]    vp_q, vp_d;
  logic [31:0]    np_q, np_d;
  logic [31:0]    cos_q, cos_d;
  logic [63:0]    t_q, t_d;
  logic [BW-1:0]  bin_q, bin_d, clr_q, clr_d;
  logic [31:0]    edge_q, edge_d;
  out_kind_e      out_q, out_d;
  logic           oob_q, oob_d;

  logic [IW-1:0]  img_addr;
  logic           img_we;
  logic [15:0]    img_rdata;
  logic [PW-1:0]  norm_addr;
  logic           norm_we;
  logic [31:0]    norm_rdata;
  logic [BW-1:0]  hist_addr;
  logic           hist_we;
  logic [31:0]    hist_wdata, hist_rdata;

  arith_req_t     arith_req;
  arith_rsp_t     arith_rsp;

  logic           accept;
  logic [PW-1:0]  pix_idx, nbr_idx;
  logic [IW-1:0]  img_addr_p, img_addr_q, ld_addr;
  logic signed [NW-1:0] nx_s, ny_s;
  logic           nx_out, ny_out;
  logic signed [9:0] dxx_s, dyy_s;
  logic [9:0]     d2;
  logic [15:0]    rr;
  logic           too_far, skip, pix_end, x_wrap, dx_wrap, off_last, k_last, nb_zero;
  logic [XCW:0]   x_inc;
  logic [KCW:0]   k_inc;
  logic           load_ok, bin_ok;
  logic [63:0]    rounded;
  logic [17:0]    bin_full;
  logic [31:0]    hist_inc;
  logic           step_off;

  assign busy_o      = (state_q != S_IDLE);
  assign cfg_ready_o = !busy_o;
  assign accept      = start_i && !busy_o;

  // clamp sizes to the store
  assign w_eff  = (32'(width_q) > MAX_WIDTH) ? XCW'(MAX_WIDTH) : XCW'(width_q);
  assign h_eff  = (32'(height_q) > MAX_HEIGHT) ? YCW'(MAX_HEIGHT) : YCW'(height_q);
  assign nb_eff = (32'(bands_q) > MAX_BANDS) ? KCW'(MAX_BANDS) : KCW'(bands_q);

  assign pix_idx = PW'(32'(y_q) * MAX_WIDTH + 32'(x_q));
  assign nx_s    = $signed(NW'(x_q)) + NW'(dx_q);
  assign ny_s    = $signed(NW'(y_q)) + NW'(dy_q);
  assign nx_out  = nx_s[NW-1] || (nx_s[NW-2:0] >= (NW-1)'(w_eff));
  assign ny_out  = ny_s[NW-1] || (ny_s[NW-2:0] >= (NW-1)'(h_eff));
  assign nbr_idx = PW'(32'(ny_s[NW-2:0]) * MAX_WIDTH + 32'(nx_s[NW-2:0]));

  assign img_addr_p = IW'(32'(pix_idx) * MAX_BANDS + 32'(k_q));
  assign img_addr_q = IW'(32'(nbr_idx) * MAX_BANDS + 32'(k_q));
  assign ld_addr    = IW'((32'(row_i) * MAX_WIDTH + 32'(column_i)) * MAX_BANDS + 32'(band_i));
  assign load_ok    = (32'(column_i) < MAX_WIDTH) && (32'(row_i) < MAX_HEIGHT)
                   && (32'(band_i) < MAX_BANDS);
  assign bin_ok     = 32'(bin_index_i) < BIN_COUNT;

  assign dxx_s   = dx_q * dx_q;
  assign dyy_s   = dy_q * dy_q;
  assign d2      = $unsigned(dxx_s) + $unsigned(dyy_s);
  assign rr      = radius_q * radius_q;
  assign too_far = {d2, 8'd0} > {2'b00, rr};
  assign span_s  = $signed({1'b0, radius_q[7:4]});
  assign skip    = (dx_q == 5'sd0 && dy_q == 5'sd0) || nx_out || ny_out || too_far;

  assign pix_end  = (y_q >= h_eff) || (w_eff == '0);
  assign x_inc    = {1'b0, x_q} + 1'b1;
  assign x_wrap   = x_inc >= {1'b0, w_eff};
  assign dx_wrap  = (dx_q == span_s);
  assign off_last = dx_wrap && (dy_q == span_s);
  assign k_inc    = {1'b0, k_q} + 1'b1;
  assign k_last   = k_inc >= {1'b0, nb_eff};
  assign nb_zero  = (nb_eff == '0);

  assign rounded  = arith_rsp.result + ROUND_HALF;
  assign bin_full = rounded[63:46];
  assign hist_inc = (hist_rdata == COUNT_MAX) ? hist_rdata : hist_rdata + 32'd1;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (accept && mode_i == MODE_RUN) state_d = S_CLR;
      S_INIT:   if (clr_q == BW'(BIN_COUNT - 1)) state_d = S_IDLE;
      S_CLR:    if (clr_q == BW'(BIN_COUNT - 1)) state_d = S_N_PIX;
      S_N_PIX: begin
        if (pix_end)      state_d = S_P_PIX;
        else if (nb_zero) state_d = S_N_SQ;
        else              state_d = S_N_RD;
      end
      S_N_RD:   state_d = S_N_MUL;
      S_N_MUL:  state_d = S_N_MACW;
      S_N_MACW: if (arith_rsp.done) state_d = k_last ? S_N_SQ : S_N_RD;
      S_N_SQ:   state_d = S_N_SQW;
      S_N_SQW:  if (arith_rsp.done) state_d = S_N_PIX;
      S_P_PIX:  state_d = pix_end ? S_DONE : S_P_CHK;
      S_P_CHK: begin
        if (skip)         state_d = off_last ? S_P_PIX : S_P_CHK;
        else if (nb_zero) state_d = S_P_NRP;
        else              state_d = S_P_RDP;
      end
      S_P_RDP:  state_d = S_P_RDQ;
      S_P_RDQ:  state_d = S_P_MUL;
      S_P_MUL:  state_d = S_P_MACW;
      S_P_MACW: if (arith_rsp.done) state_d = k_last ? S_P_NRP : S_P_RDP;
      S_P_NRP:  state_d = S_P_NRQ;
      S_P_NRQ:  state_d = S_P_DQ;
      S_P_DQ:   state_d = S_P_DQW;
      S_P_DQW:  if (arith_rsp.done) state_d = S_P_COS;
      S_P_COS:  state_d = (t_q == '0) ? S_P_RSQ : S_P_COSW;
      S_P_COSW: if (arith_rsp.done) state_d = S_P_RSQ;
      S_P_RSQ:  state_d = S_P_RSQW;
      S_P_RSQW: if (arith_rsp.done) state_d = S_P_RAT;
      S_P_RAT:  state_d = S_P_RATW;
      S_P_RATW: if (arith_rsp.done) state_d = S_P_BIN;
      S_P_BIN:  state_d = S_P_BINW;
      S_P_BINW: if (arith_rsp.done) state_d = S_P_HRD;
      S_P_HRD:  state_d = S_P_HWR;
      S_P_HWR:  state_d = off_last ? S_P_PIX : S_P_CHK;
      S_DONE:   state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    x_d = x_q; y_d = y_q; k_d = k_q; dx_d = dx_q; dy_d = dy_q;
    acc_d = acc_q; vp_d = vp_q; np_d = np_q; cos_d = cos_q; t_d = t_q;
    bin_d = bin_q; clr_d = clr_q; edge_d = edge_q;
    out_d = OUT_NONE; oob_d = oob_q;
    step_off   = 1'b0;
    img_addr   = ld_addr;
    img_we     = 1'b0;
    norm_addr  = pix_idx;
    norm_we    = 1'b0;
    hist_addr  = BW'(bin_index_i);
    hist_we    = 1'b0;
    hist_wdata = '0;
    arith_req  = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (mode_i)
            MODE_LOAD:     img_we = load_ok;
            MODE_RUN: begin
              clr_d  = '0;
              edge_d = '0;
              x_d    = '0;
              y_d    = '0;
            end
            MODE_READ_BIN: begin
              out_d = OUT_BIN;
              oob_d = !bin_ok;
            end
            MODE_READ_EDGE: out_d = OUT_EDGE;
            default:        out_d = OUT_NONE;
          endcase
        end
      end
      S_INIT, S_CLR: begin
        hist_addr = clr_q;
        hist_we   = 1'b1;
        clr_d     = clr_q + 1'b1;
      end
      S_N_PIX: begin
        acc_d = '0;
        k_d   = '0;
        // rewind to the first pixel for the pair pass
        if (pix_end) begin
          x_d = '0;
          y_d = '0;
        end
      end
      S_N_RD:  img_addr = img_addr_p;
      S_N_MUL: begin
        arith_req.start = 1'b1;
        arith_req.op    = OP_MUL;
        arith_req.opa   = 64'({1'b1, img_rdata});
        arith_req.opb   = 64'({1'b1, img_rdata});
      end
      S_N_MACW, S_P_MACW: begin
        if (arith_rsp.done) begin
          acc_d = acc_q + arith_rsp.result[39:0];
          k_d   = k_inc[KCW-1:0];
        end
      end
      S_N_SQ: begin
        arith_req.start = 1'b1;
        arith_req.op    = OP_SQRT;
        arith_req.opa   = 64'(acc_q) << NUM_SHIFT;
      end
      S_N_SQW: begin
        if (arith_rsp.done) begin
          norm_we = 1'b1;
          if (x_wrap) begin
            x_d = '0;
            y_d = y_q + 1'b1;
          end else begin
            x_d = x_inc[XCW-1:0];
          end
        end
      end
      S_P_PIX: begin
        dx_d = -span_s;
        dy_d = -span_s;
      end
      S_P_CHK: begin
        if (skip) begin
          step_off = 1'b1;
        end else begin
          acc_d = '0;
          k_d   = '0;
        end
      end
      S_P_RDP: img_addr = img_addr_p;
      S_P_RDQ: begin
        img_addr = img_addr_q;
        vp_d     = {1'b1, img_rdata};
      end
      S_P_MUL: begin
        arith_req.start = 1'b1;
        arith_req.op    = OP_MUL;
        arith_req.opa   = 64'(vp_q);
        arith_req.opb   = 64'({1'b1, img_rdata});
      end
      S_P_NRP: norm_addr = pix_idx;
      S_P_NRQ: begin
        norm_addr = nbr_idx;
        np_d      = norm_rdata;
      end
      S_P_DQ: begin
        arith_req.start = 1'b1;
        arith_req.op    = OP_MUL;
        arith_req.opa   = 64'(np_q);
        arith_req.opb   = 64'(norm_rdata);
      end
      S_P_DQW, S_P_RSQW, S_P_RATW: begin
        if (arith_rsp.done) t_d = arith_rsp.result;
      end
      S_P_COS: begin
        // zero norm product gives zero cosine
        if (t_q == '0) begin
          cos_d = '0;
        end else begin
          arith_req.start = 1'b1;
          arith_req.op    = OP_DIV;
          arith_req.opa   = 64'(acc_q) << NUM_SHIFT;
          arith_req.opb   = t_q;
        end
      end
      S_P_COSW: if (arith_rsp.done) cos_d = arith_rsp.result[31:0];
      S_P_RSQ: begin
        arith_req.start = 1'b1;
        arith_req.op    = OP_SQRT;
        arith_req.opa   = 64'(d2) << DIST_SHIFT;
      end
      S_P_RAT: begin
        arith_req.start = 1'b1;
        arith_req.op    = OP_DIV;
        arith_req.opa   = t_q;
        arith_req.opb   = 64'(radius_q) << RADIUS_SHIFT;
      end
      S_P_BIN: begin
        arith_req.start = 1'b1;
        arith_req.op    = OP_MUL;
        arith_req.opa   = 64'(cos_q);
        arith_req.opb   = 64'(t_q[31:0]);
      end
      S_P_BINW: begin
        if (arith_rsp.done) begin
          bin_d = (32'(bin_full) >= BIN_COUNT) ? BW'(BIN_COUNT - 1) : BW'(bin_full);
        end
      end
      S_P_HRD: hist_addr = bin_q;
      S_P_HWR: begin
        hist_addr  = bin_q;
        hist_we    = 1'b1;
        hist_wdata = hist_inc;
        edge_d     = (edge_q == COUNT_MAX) ? edge_q : edge_q + 32'd1;
        step_off   = 1'b1;
      end
      S_DONE:  out_d = OUT_RUN;
      default: out_d = OUT_NONE;
    endcase

    // advance to the next offset, or to the next pixel after the last one
    if (step_off) begin
      if (off_last) begin
        if (x_wrap) begin
          x_d = '0;
          y_d = y_q + 1'b1;
        end else begin
          x_d = x_inc[XCW-1:0];
        end
      end else if (dx_wrap) begin
        dx_d = -span_s;
        dy_d = dy_q + 5'sd1;
      end else begin
        dx_d = dx_q + 5'sd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_INIT;
      out_q    <= OUT_NONE;
      edge_q   <= '0;
      clr_q    <= '0;
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
      bands_q  <= BANDS_RESET;
      radius_q <= RADIUS_RESET;
    end else begin
      state_q <= state_d;
      out_q   <= out_d;
      edge_q  <= edge_d;
      clr_q   <= clr_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_WIDTH:  width_q  <= cfg_data_i;
          CFG_HEIGHT: height_q <= cfg_data_i;
          CFG_BANDS:  bands_q  <= cfg_data_i[5:0];
          CFG_RADIUS: radius_q <= cfg_data_i[7:0];
          default:    radius_q <= radius_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    k_q   <= k_d;
    dx_q  <= dx_d;
    dy_q  <= dy_d;
    acc_q <= acc_d;
    vp_q  <= vp_d;
    np_q  <= np_d;
    cos_q <= cos_d;
    t_q   <= t_d;
    bin_q <= bin_d;
    oob_q <= oob_d;
  end

  cewh_ram #(.WIDTH(16), .DEPTH(IMG_DEPTH)) u_img_ram (
    .clk_i   (clk_i),
    .addr_i  (img_addr),
    .we_i    (img_we),
    .wdata_i (sample_i),
    .rdata_o (img_rdata)
  );

  cewh_ram #(.WIDTH(32), .DEPTH(PIX_DEPTH)) u_norm_ram (
    .clk_i   (clk_i),
    .addr_i  (norm_addr),
    .we_i    (norm_we),
    .wdata_i (arith_rsp.result[31:0]),
    .rdata_o (norm_rdata)
  );

  cewh_ram #(.WIDTH(32), .DEPTH(BIN_COUNT)) u_hist_ram (
    .clk_i   (clk_i),
    .addr_i  (hist_addr),
    .we_i    (hist_we),
    .wdata_i (hist_wdata),
    .rdata_o (hist_rdata)
  );

  cewh_arith u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (arith_req),
    .rsp_o  (arith_rsp)
  );

  assign result_valid_o = (out_q != OUT_NONE);
  assign run_done_o     = (out_q == OUT_RUN);

  always_comb begin
    unique case (out_q)
      OUT_BIN:  read_value_o = oob_q ? 32'd0 : hist_rdata;
      OUT_EDGE: read_value_o = edge_q;
      OUT_RUN:  read_value_o = edge_q;
      default:  read_value_o = '0;
    endcase
  end

  a_hist_write_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hist_we |-> (state_q != S_IDLE))
    else $error("histogram written outside a run");

  a_result_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (state_q == S_IDLE))
    else $error("result strobe during a run");

  a_run_starts_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && mode_i == MODE_RUN) |=> (state_q == S_CLR && clr_q == '0 && edge_q == '0))
    else $error("run did not start with a clearing pass");

endmodule

[sim/tb_cosine_edge_weight_histogram_unit.sv]
// Self-checking testbench of the cosine edge-weight histogram unit.
`timescale 1ns / 100ps

module tb_cosine_edge_weight_histogram_unit;
  import cewh_pkg::*;

  localparam int IDLE_LIMIT = 1_000_000;

  typedef struct {
    logic [31:0] value;
    logic        done;
  } answer_t;

  // Predicts the block and holds the answers it still owes.
  class weight_hist_board;
    logic [15:0]     img [int];
    int unsigned     hist [int];
    int unsigned     edges;
    int unsigned     width, height, bands, radius;
    longint unsigned norms [65536];
    answer_t         owed [$];
    int              fails;

    function new();
      edges  = 0;
      width  = WIDTH_RESET;
      height = HEIGHT_RESET;
      bands  = BANDS_RESET;
      radius = RADIUS_RESET;
      fails  = 0;
    endfunction

    function longint unsigned isqrt(longint unsigned v);
      longint unsigned res, bt;
      res = 0;
      bt  = SQRT_TOP_BIT;
      while (bt > v) bt >>= 2;
      while (bt != 0) begin
        if (v >= res + bt) begin
          v   = v - (res + bt);
          res = (res >> 1) + bt;
        end else begin
          res >>= 1;
        end
        bt >>= 2;
      end
      return res;
    endfunction

    function longint unsigned q31_ratio(longint unsigned a, longint unsigned b);
      longint unsigned q, rem;
      if (a / b >= 1) return Q31_ONE;
      q   = 0;
      rem = a;
      for (int i = 0; i < DIV_STEPS; i++) begin
        rem <<= 1;
        q   <<= 1;
        if (rem >= b) begin
          rem = rem - b;
          q   = q | 1;
        end
      end
      return q;
    endfunction

    function longint unsigned band_val(int p, int k);
      longint unsigned s;
      s = img.exists(p * 32 + k) ? img[p * 32 + k] : 0;
      return s + 65536;
    endfunction

    function void sweep();
      int w, h, nb, span, p, q, nx, ny;
      longint unsigned rr, den, d2, num, dq, cosv, ratio, bin;
      w    = width > 256 ? 256 : width;
      h    = height > 256 ? 256 : height;
      nb   = bands > 32 ? 32 : bands;
      rr   = longint'(radius) * radius;
      span = radius >> 4;
      hist.delete();
      edges = 0;
      for (int y = 0; y < h; y++)
        for (int x = 0; x < w; x++) begin
          p   = y * 256 + x;
          den = 0;
          for (int k = 0; k < nb; k++) den += band_val(p, k) * band_val(p, k);
          norms[p] = isqrt(den << NUM_SHIFT);
        end
      for (int y = 0; y < h; y++)
        for (int x = 0; x < w; x++) begin
          p = y * 256 + x;
          for (int dy = -span; dy <= span; dy++)
            for (int dx = -span; dx <= span; dx++) begin
              nx = x + dx;
              ny = y + dy;
              if (dx == 0 && dy == 0) continue;
              if (nx < 0 || ny < 0 || nx >= w || ny >= h) continue;
              d2 = dx * dx + dy * dy;
              if (d2 * 256 > rr) continue;
              q   = ny * 256 + nx;
              num = 0;
              for (int k = 0; k < nb; k++) num += band_val(p, k) * band_val(q, k);
              dq    = norms[p] * norms[q];
              cosv  = dq != 0 ? q31_ratio(num << NUM_SHIFT, dq) : 0;
              ratio = q31_ratio(isqrt(d2 << DIST_SHIFT),
                                longint'(radius) << RADIUS_SHIFT);
              bin   = (cosv * ratio + ROUND_HALF) >> 46;
              if (bin >= 65537) bin = 65536;
              if (!hist.exists(int'(bin))) hist[int'(bin)] = 0;
              if (hist[int'(bin)] != COUNT_MAX) hist[int'(bin)]++;
              if (edges != COUNT_MAX) edges++;
            end
        end
    endfunction

    function void set_reg(logic [1:0] idx, logic [8:0] data);
      case (idx)
        CFG_WIDTH:  width  = data;
        CFG_HEIGHT: height = data;
        CFG_BANDS:  bands  = data[5:0];
        CFG_RADIUS: radius = data[7:0];
        default: ;
      endcase
    endfunction

    function void note_command(logic [1:0] mode, logic [7:0] col, logic [7:0] row,
                               logic [4:0] band, logic [15:0] smp, logic [16:0] bidx);
      answer_t a;
      a.done = 1'b0;
      case (mode)
        MODE_LOAD: begin
          img[(int'(row) * 256 + int'(col)) * 32 + int'(band)] = smp;
          return;
        end
        MODE_RUN: begin
          sweep();
          a.value = edges;
          a.done  = 1'b1;
        end
        MODE_READ_BIN: a.value = (bidx < 65537 && hist.exists(int'(bidx))) ?
                                 hist[int'(bidx)] : 0;
        default: a.value = edges;
      endcase
      owed.push_back(a);
    endfunction

    function void check_result(logic [31:0] value, logic done);
      answer_t a;
      if (owed.size() == 0) begin
        fails++;
        if (fails <= 10) $display("unexpected result value=%0d done=%0b", value, done);
        return;
      end
      a = owed.pop_front();
      if (value !== a.value || done !== a.done) begin
        fails++;
        if (fails <= 10)
          $display("mismatch: value exp %0d got %0d, done exp %0b got %0b",
                   a.value, value, a.done, done);
      end
    endfunction

    // Mostly a bin that the last run hit, sometimes any 17-bit index.
    function logic [16:0] pick_bin();
      int n, key;
      if (hist.num() == 0 || $urandom_range(0, 9) < 3) begin
        case ($urandom_range(0, 3))
          0:       return 17'd65536;
          1:       return 17'(65537 + $urandom_range(0, 65534));
          default: return 17'($urandom_range(0, 131071));
        endcase
      end
      n = $urandom_range(0, hist.num() - 1);
      void'(hist.first(key));
      repeat (n) void'(hist.next(key));
      return 17'(key);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [1:0]  mode_i = MODE_LOAD;
  logic [7:0]  column_i = '0;
  logic [7:0]  row_i = '0;
  logic [4:0]  band_i = '0;
  logic [15:0] sample_i = '0;
  logic [16:0] bin_index_i = '0;
  logic        result_valid_o;
  logic [31:0] read_value_o;
  logic        run_done_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = CFG_WIDTH;
  logic [8:0]  cfg_data_i = '0;

  weight_hist_board board;
  int burst_left = 0;
  int idle_cycles = 0;

  cosine_edge_weight_histogram_unit uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && board != null) begin
      if (result_valid_o) board.check_result(read_value_o, run_done_o);
      if (result_valid_o || (start_i && !busy_o) || (cfg_valid_i && cfg_ready_o))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Entered and left at a falling edge.
  task automatic send_cmd(logic [1:0] mode, logic [7:0] col, logic [7:0] row,
                          logic [4:0] band, logic [15:0] smp, logic [16:0] bidx);
    start_i     = 1'b1;
    mode_i      = mode;
    column_i    = col;
    row_i       = row;
    band_i      = band;
    sample_i    = smp;
    bin_index_i = bidx;
    do @(posedge clk_i); while (busy_o);
    board.note_command(mode, col, row, band, smp, bidx);
    @(negedge clk_i);
    if (burst_left == 0) begin
      start_i = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 40) : $urandom_range(0, 8);
    end else begin
      burst_left--;
    end
  endtask

  task automatic read_any();
    if ($urandom_range(0, 4) == 0)
      send_cmd(MODE_READ_EDGE, 8'($urandom), 8'($urandom), 5'($urandom),
               16'($urandom), 17'($urandom));
    else
      send_cmd(MODE_READ_BIN, 8'($urandom), 8'($urandom), 5'($urandom),
               16'($urandom), board.pick_bin());
  endtask

  task automatic wait_idle();
    start_i = 1'b0;
    while (board.owed.size() != 0 || busy_o) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [8:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.set_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Set the size, fill every sample the run reads, run, then read back.
  task automatic phase(int w, int h, int nb, int r, int reads);
    int cells [$];
    int cw, ch, cb, j, tmp, addr;
    wait_idle();
    write_reg(CFG_WIDTH, 9'(w));
    write_reg(CFG_HEIGHT, 9'(h));
    write_reg(CFG_BANDS, 9'(nb));
    write_reg(CFG_RADIUS, 9'(r));
    @(negedge clk_i);
    cw = w > 256 ? 256 : w;
    ch = h > 256 ? 256 : h;
    cb = nb > 32 ? 32 : nb;
    for (int y = 0; y < ch; y++)
      for (int x = 0; x < cw; x++)
        for (int k = 0; k < cb; k++) cells.push_back((y * 256 + x) * 32 + k);
    for (int i = cells.size() - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      tmp      = cells[i];
      cells[i] = cells[j];
      cells[j] = tmp;
    end
    foreach (cells[i]) begin
      addr = cells[i];
      send_cmd(MODE_LOAD, addr[12:5], addr[20:13], addr[4:0], pick_sample(),
               17'($urandom));
      case ($urandom_range(0, 9))
        0: send_cmd(MODE_LOAD, 8'($urandom), 8'($urandom), 5'($urandom),
                    16'($urandom), 17'($urandom));
        1: read_any();
        default: ;
      endcase
    end
    send_cmd(MODE_RUN, 8'($urandom), 8'($urandom), 5'($urandom), 16'($urandom),
             17'($urandom));
    repeat (reads) read_any();
  endtask

  initial begin
    board = new();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reads before any run see an empty histogram.
    send_cmd(MODE_READ_EDGE, 8'hFF, 8'hFF, 5'h1F, 16'hFFFF, 17'h1FFFF);
    send_cmd(MODE_READ_BIN, '0, '0, '0, '0, 17'd0);
    send_cmd(MODE_READ_BIN, '0, '0, '0, '0, 17'd65536);
    send_cmd(MODE_READ_BIN, '0, '0, '0, '0, 17'd65537);
    send_cmd(MODE_READ_BIN, '0, '0, '0, '0, 17'h1FFFF);
    send_cmd(MODE_LOAD, 8'hFF, 8'hFF, 5'h1F, 16'hFFFF, '0);

    phase(3, 2, 2, 16, 20);
    phase(3, 2, 2, 15, 10);        // radius below one pixel
    phase(0, 5, 3, 40, 6);         // zero width
    phase(3, 3, 0, 40, 12);        // no bands
    phase(511, 1, 1, 16, 50);      // width clamped to 256
    phase(1, 256, 1, 16, 50);
    phase(2, 1, 32, 255, 15);
    phase(4, 4, 3, 255, 50);
    phase(5, 3, 4, $urandom_range(16, 60), 80);

    wait_idle();
    repeat (20) @(negedge clk_i);
    if (board.fails == 0 && board.owed.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
